// File: src/wosf_pkg.sv
package wosf_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SCALE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_POSITION = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_VELOCITY = 2'd3;

    localparam logic [16:0] ALPHA_ONE = 17'h10000;

    // Shared multiplier widths: signed 34-bit operand times unsigned 24-bit operand
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = 59;
    localparam int RND_W   = 43;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] right_pos;
        logic signed [31:0] right_vel;
        logic signed [31:0] left_pos;
        logic signed [31:0] left_vel;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] distance_estimate;
        logic signed [31:0] angle_estimate;
        logic signed [31:0] velocity_estimate;
        logic signed [31:0] turn_rate_estimate;
    } result_t;

    typedef struct packed {
        logic [15:0] radius;
        logic [23:0] angle_scale;
        logic [16:0] alpha_position;
        logic [16:0] alpha_velocity;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_FLUSH,
        ST_DONE
    } seq_state_t;

    // Operations issued to the shared multiplier, in issue order
    typedef logic [2:0] op_t;
    localparam op_t OP_DIST_POS     = 3'd0;
    localparam op_t OP_ANGLE_POS    = 3'd1;
    localparam op_t OP_SMOOTH_DIST  = 3'd2;
    localparam op_t OP_SMOOTH_ANGLE = 3'd3;
    localparam op_t OP_DIST_VEL     = 3'd4;
    localparam op_t OP_ANGLE_VEL    = 3'd5;
    localparam op_t OP_SMOOTH_VEL   = 3'd6;
    localparam op_t OP_SMOOTH_TURN  = 3'd7;
    localparam op_t OP_LAST         = OP_SMOOTH_TURN;

    typedef struct packed {
        logic capture;
        logic clear;
        logic prep;
        logic issue;
        op_t  issue_op;
        logic post;
        op_t  post_op;
        logic load_out;
    } ctrl_t;

endpackage

// File: src/wosf_cfg_regs.sv
module wosf_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wosf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wosf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output wosf_pkg::cfg_t                   cfg
);
    import wosf_pkg::*;

    cfg_t        cfg_reg;
    logic [16:0] alpha_clamped;

    // Weights above one act as one
    assign alpha_clamped = (cfg_data[16] && (cfg_data[15:0] != 16'd0)) ? ALPHA_ONE
                                                                        : cfg_data[16:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius         <= '0;
            cfg_reg.angle_scale    <= '0;
            cfg_reg.alpha_position <= ALPHA_ONE;
            cfg_reg.alpha_velocity <= ALPHA_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WHEEL_RADIUS:   cfg_reg.radius         <= cfg_data[15:0];
                CFG_ANGLE_SCALE:    cfg_reg.angle_scale    <= cfg_data[23:0];
                CFG_ALPHA_POSITION: cfg_reg.alpha_position <= alpha_clamped;
                CFG_ALPHA_VELOCITY: cfg_reg.alpha_velocity <= alpha_clamped;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/wosf_mul_unit.sv
module wosf_mul_unit (
    input  logic                                    clk,
    input  logic                                    issue,
    input  logic signed [wosf_pkg::MUL_A_W-1:0]     op_a,
    input  logic        [wosf_pkg::MUL_B_W-1:0]     op_b,
    input  logic                                    shift17,
    output logic signed [wosf_pkg::RND_W-1:0]       rnd,
    output logic signed [31:0]                      sat
);
    import wosf_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF17 = PROD_W'(65536);
    localparam logic signed [PROD_W-1:0] HALF16 = PROD_W'(32768);
    localparam logic signed [RND_W-1:0]  SAT_MAX = RND_W'(64'sd2147483647);
    localparam logic signed [RND_W-1:0]  SAT_MIN = RND_W'(-64'sd2147483648);

    logic signed [MUL_B_W:0]   b_ext;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      s17_reg;
    logic signed [PROD_W-1:0]  biased;
    logic signed [PROD_W-1:0]  shifted;

    assign b_ext     = signed'({1'b0, op_b});
    assign prod_full = op_a * b_ext;

    // Register the product; rounding happens in the following cycle
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= prod_full;
            s17_reg  <= shift17;
        end
    end

    // Round to nearest, ties toward plus infinity, then arithmetic shift
    always_comb
    begin
        biased  = prod_reg + (s17_reg ? HALF17 : HALF16);
        shifted = s17_reg ? (biased >>> 17) : (biased >>> 16);
        rnd     = signed'(shifted[RND_W-1:0]);
        if (rnd > SAT_MAX)
            sat = 32'sh7FFFFFFF;
        else if (rnd < SAT_MIN)
            sat = 32'sh80000000;
        else
            sat = signed'(rnd[31:0]);
    end

endmodule

// File: src/wosf_seq.sv
module wosf_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample_valid,
    input  logic            req_type,
    input  logic            result_blocked,
    output logic            busy,
    output wosf_pkg::ctrl_t ctrl
);
    import wosf_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;
    op_t        op_reg;
    op_t        op_next;
    logic       post_vld_reg;
    op_t        post_op_reg;
    logic       accept;

    assign accept = sample_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = req_type ? ST_DONE : ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_RUN;
                op_next    = OP_DIST_POS;
            end
            ST_RUN:
            begin
                op_next = op_reg + 3'd1;
                if (op_reg == OP_LAST)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (!result_blocked)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy          = (state_reg != ST_IDLE);
        ctrl.capture  = accept && !req_type;
        ctrl.clear    = accept && req_type;
        ctrl.prep     = (state_reg == ST_PREP);
        ctrl.issue    = (state_reg == ST_RUN);
        ctrl.issue_op = op_reg;
        ctrl.post     = post_vld_reg;
        ctrl.post_op  = post_op_reg;
        ctrl.load_out = (state_reg == ST_DONE) && !result_blocked;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_DIST_POS;
            post_vld_reg <= 1'b0;
            post_op_reg  <= OP_DIST_POS;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            post_vld_reg <= (state_reg == ST_RUN);
            post_op_reg  <= op_reg;
        end
    end

endmodule

// File: src/wheel_odometry_smoothing_filter.sv
// Differential-drive odometry with exponential smoothing. A sample transfer with
// req_type 0 takes right/left wheel positions and velocities (signed Q16.16),
// forms distance = (r + l) / 2 * radius and angle = (r - l) * angle_scale
// for both the positions (relative to the stored origins) and the velocities,
// and folds each into its running average est += alpha * (x - est). A transfer
// with req_type 1 stores the given positions as new origins and clears the four
// averages; its result is all zeros. Every sample transfer yields exactly one
// result transfer carrying all four estimates, rounded to nearest (ties up) and
// saturated to the signed 32-bit range. One 34x25-bit multiplier is
// shared by eight products per sample (four scalings, four smoothing steps), so
// a filter sample passes through the PREP, RUN and FLUSH states to DONE before
// the next transfer is accepted; a reset item goes straight to DONE. sample_stall
// stays high while an item is in work. The result sits in an output register, so
// a new item is taken while the previous result still waits; an item finishes
// only once that register is free. Configuration writes take effect at once and
// are meant for idle periods; alpha keeps bits 16:0, above 65536 acting as 65536.
module wheel_odometry_smoothing_filter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  wosf_pkg::sample_t                sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output wosf_pkg::result_t                result,
    input  logic                             cfg_we,
    input  logic [wosf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wosf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wosf_pkg::*;

    cfg_t  cfg;
    ctrl_t ctrl;
    logic  result_blocked;

    // Persistent filter state
    logic signed [31:0] right_origin_reg;
    logic signed [31:0] left_origin_reg;
    logic signed [31:0] dist_avg_reg;
    logic signed [31:0] angle_avg_reg;
    logic signed [31:0] vel_avg_reg;
    logic signed [31:0] turn_avg_reg;

    // Per-item working registers
    logic signed [32:0] r_rel_reg;
    logic signed [32:0] l_rel_reg;
    logic signed [31:0] rv_reg;
    logic signed [31:0] lv_reg;
    logic signed [33:0] pos_sum_reg;
    logic signed [33:0] pos_diff_reg;
    logic signed [33:0] vel_sum_reg;
    logic signed [33:0] vel_diff_reg;
    logic signed [32:0] d_dist_reg;
    logic signed [32:0] d_angle_reg;
    logic signed [32:0] d_vel_reg;
    logic signed [32:0] d_turn_reg;

    // Multiplier operands and results
    logic signed [MUL_A_W-1:0] op_a;
    logic        [MUL_B_W-1:0] op_b;
    logic                      shift17;
    logic signed [RND_W-1:0]   rnd;
    logic signed [31:0]        sat;

    logic    result_valid_reg;
    logic    result_valid_next;
    result_t result_reg;

    assign result_blocked = result_valid_reg && result_stall;

    wosf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wosf_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .req_type       (sample.req_type),
        .result_blocked (result_blocked),
        .busy           (sample_stall),
        .ctrl           (ctrl)
    );

    wosf_mul_unit u_mul (
        .clk     (clk),
        .issue   (ctrl.issue),
        .op_a    (op_a),
        .op_b    (op_b),
        .shift17 (shift17),
        .rnd     (rnd),
        .sat     (sat)
    );

    // Operand select: scalings use sums/differences, smoothing uses x - est
    always_comb
    begin
        op_a    = pos_sum_reg;
        op_b    = {8'd0, cfg.radius};
        shift17 = 1'b1;
        case (ctrl.issue_op)
            OP_DIST_POS:
            begin
                op_a    = pos_sum_reg;
                op_b    = {8'd0, cfg.radius};
                shift17 = 1'b1;
            end
            OP_ANGLE_POS:
            begin
                op_a    = pos_diff_reg;
                op_b    = cfg.angle_scale;
                shift17 = 1'b0;
            end
            OP_SMOOTH_DIST:
            begin
                op_a    = MUL_A_W'(d_dist_reg);
                op_b    = {7'd0, cfg.alpha_position};
                shift17 = 1'b0;
            end
            OP_SMOOTH_ANGLE:
            begin
                op_a    = MUL_A_W'(d_angle_reg);
                op_b    = {7'd0, cfg.alpha_position};
                shift17 = 1'b0;
            end
            OP_DIST_VEL:
            begin
                op_a    = vel_sum_reg;
                op_b    = {8'd0, cfg.radius};
                shift17 = 1'b1;
            end
            OP_ANGLE_VEL:
            begin
                op_a    = vel_diff_reg;
                op_b    = cfg.angle_scale;
                shift17 = 1'b0;
            end
            OP_SMOOTH_VEL:
            begin
                op_a    = MUL_A_W'(d_vel_reg);
                op_b    = {7'd0, cfg.alpha_velocity};
                shift17 = 1'b0;
            end
            OP_SMOOTH_TURN:
            begin
                op_a    = MUL_A_W'(d_turn_reg);
                op_b    = {7'd0, cfg.alpha_velocity};
                shift17 = 1'b0;
            end
            default:
            begin
                op_a    = pos_sum_reg;
                op_b    = {8'd0, cfg.radius};
                shift17 = 1'b1;
            end
        endcase
    end

    // Capture inputs relative to the origins, then form sums and differences
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            r_rel_reg <= 33'(sample.right_pos) - 33'(right_origin_reg);
            l_rel_reg <= 33'(sample.left_pos) - 33'(left_origin_reg);
            rv_reg    <= sample.right_vel;
            lv_reg    <= sample.left_vel;
        end
        if (ctrl.prep)
        begin
            pos_sum_reg  <= 34'(r_rel_reg) + 34'(l_rel_reg);
            pos_diff_reg <= 34'(r_rel_reg) - 34'(l_rel_reg);
            vel_sum_reg  <= 34'(rv_reg) + 34'(lv_reg);
            vel_diff_reg <= 34'(rv_reg) - 34'(lv_reg);
        end
    end

    // Post-processing of a scaling: hold the step toward the new value
    always_ff @(posedge clk)
    begin
        if (ctrl.post)
        begin
            case (ctrl.post_op)
                OP_DIST_POS:  d_dist_reg  <= 33'(sat) - 33'(dist_avg_reg);
                OP_ANGLE_POS: d_angle_reg <= 33'(sat) - 33'(angle_avg_reg);
                OP_DIST_VEL:  d_vel_reg   <= 33'(sat) - 33'(vel_avg_reg);
                OP_ANGLE_VEL: d_turn_reg  <= 33'(sat) - 33'(turn_avg_reg);
                default:      d_dist_reg  <= d_dist_reg;
            endcase
        end
    end

    // Origins and averages; a smoothing result lies between est and x, so the
    // 32-bit sum cannot wrap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_origin_reg <= '0;
            left_origin_reg  <= '0;
            dist_avg_reg     <= '0;
            angle_avg_reg    <= '0;
            vel_avg_reg      <= '0;
            turn_avg_reg     <= '0;
        end
        else if (ctrl.clear)
        begin
            right_origin_reg <= sample.right_pos;
            left_origin_reg  <= sample.left_pos;
            dist_avg_reg     <= '0;
            angle_avg_reg    <= '0;
            vel_avg_reg      <= '0;
            turn_avg_reg     <= '0;
        end
        else if (ctrl.post)
        begin
            case (ctrl.post_op)
                OP_SMOOTH_DIST:  dist_avg_reg  <= dist_avg_reg + signed'(rnd[31:0]);
                OP_SMOOTH_ANGLE: angle_avg_reg <= angle_avg_reg + signed'(rnd[31:0]);
                OP_SMOOTH_VEL:   vel_avg_reg   <= vel_avg_reg + signed'(rnd[31:0]);
                OP_SMOOTH_TURN:  turn_avg_reg  <= turn_avg_reg + signed'(rnd[31:0]);
                default:         dist_avg_reg  <= dist_avg_reg;
            endcase
        end
    end

    // Output register: load when free or being drained, drop valid after transfer
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (ctrl.load_out)
            result_valid_next = 1'b1;
        else if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            result_reg.distance_estimate  <= dist_avg_reg;
            result_reg.angle_estimate     <= angle_avg_reg;
            result_reg.velocity_estimate  <= vel_avg_reg;
            result_reg.turn_rate_estimate <= turn_avg_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> sample_stall)
        else $error("block took a new item while one was in work");

    a_reset_item_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall && sample.req_type) |=>
        (dist_avg_reg == 32'sd0 && angle_avg_reg == 32'sd0 &&
         vel_avg_reg == 32'sd0 && turn_avg_reg == 32'sd0))
        else $error("reset item left an average nonzero");

    a_sample_keeps_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall && !sample.req_type) |=>
        ($stable(right_origin_reg) && $stable(left_origin_reg)))
        else $error("filter sample moved an origin");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |=> result_valid)
        else $error("result load did not raise result_valid");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> !ctrl.load_out)
        else $error("pending result overwritten");

endmodule
